FILE: hdl/fra_pkg.sv
// ----------------------------------------------------------------------------
// fra_pkg: shared definitions for the fenced ring allocator
// Item modes, result status codes, defaults and the record store controls.
// ----------------------------------------------------------------------------
`default_nettype none

package fra_pkg;

	// defaults for the top-level parameters
	localparam int RECORD_DEPTH_DEF = 64;
	localparam int OFFSET_BITS_DEF  = 32;

	// region size after reset
	localparam logic [31:0] REGION_RESET = 32'd65536;

	// item modes, carried in s_tuser
	localparam logic [1:0] MODE_ALLOC   = 2'd0;
	localparam logic [1:0] MODE_TAG     = 2'd1;
	localparam logic [1:0] MODE_RECLAIM = 2'd2;

	// result status, carried in m_tuser
	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_NOROOM = 2'd1;
	localparam logic [1:0] STATUS_FULL   = 2'd2;

	// stream payload widths
	localparam int IN_DATA_W  = 120;
	localparam int OUT_DATA_W = 72;

	// record store controls from the sequencer
	typedef struct packed {
		logic alloc_we;  // write a new untagged record
		logic fence_we;  // stamp the fence of one record
		logic rd_en;     // read the record at the read address
	} fra_store_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/fra_alu.sv
// ----------------------------------------------------------------------------
// fra_alu: shared add / subtract unit
// One adder used for the offset, end and fence sums and compares of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module fra_alu #(
	parameter int W = 64
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	input  wire logic         sub,    // 1: a - b, 0: a + b
	output logic      [W-1:0] sum,
	output logic              carry   // on subtract: 1 when a >= b
);

	logic [W-1:0] b_eff;

	// invert the second operand for a subtract, carry in supplies the +1
	assign b_eff = sub ? ~b : b;
	assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, sub};

endmodule

`default_nettype wire

FILE: hdl/fra_store.sv
// ----------------------------------------------------------------------------
// fra_store: record store
// Offset, size and fence of each grant in one-write, one-read memories.
// ----------------------------------------------------------------------------
`default_nettype none

module fra_store #(
	parameter int DEPTH = fra_pkg::RECORD_DEPTH_DEF,
	parameter int OB    = fra_pkg::OFFSET_BITS_DEF,
	parameter int IW    = $clog2(DEPTH)
) (
	input  wire logic                   clk,
	input  wire fra_pkg::fra_store_ctl_t ctl,
	input  wire logic [IW-1:0]          wr_addr,
	input  wire logic [OB-1:0]          wr_offset,
	input  wire logic [31:0]            wr_size,
	input  wire logic [63:0]            wr_fence,
	input  wire logic [IW-1:0]          rd_addr,
	output logic      [OB-1:0]          rd_offset,
	output logic      [31:0]            rd_size,
	output logic      [63:0]            rd_fence
);

	logic [OB-1:0] offset_mem [DEPTH];
	logic [31:0]   size_mem   [DEPTH];
	logic [63:0]   fence_mem  [DEPTH];

	// write a new record, or stamp a fence
	always_ff @(posedge clk) begin
		if (ctl.alloc_we) begin
			offset_mem[wr_addr] <= wr_offset;
			size_mem[wr_addr]   <= wr_size;
		end
		if (ctl.alloc_we || ctl.fence_we) begin
			fence_mem[wr_addr] <= wr_fence;
		end
	end

	// registered read of the oldest record
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_offset <= offset_mem[rd_addr];
			rd_size   <= size_mem[rd_addr];
			rd_fence  <= fence_mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/fenced_ring_allocator.sv
// ----------------------------------------------------------------------------
// fenced_ring_allocator: circular space allocator with fence reclaim
// Requests arrive on s_* (mode in s_tuser), one result leaves on m_* per
// request (status in m_tuser). region_size is written on cfg_*, only while
// idle; a write empties the record store and restarts head and tail.
// cfg_ready is high only while the sequencer is idle, and a pending write
// holds s_tready low so a request and a write never share an edge.
// One shared adder under a sequencer does the offset and fence sums and
// compares, so s_tready is high only between requests. Sequencer steps:
//   allocate: align, end, two or three compares; straight to result when full;
//   tag: one fence write per cycle for each pending record;
//   reclaim: check, then per record fence compare, end sum, wrap compare/subtract.
// The record store has one read port; reclaim reads one record at a time.
// The result sits in an output register: a stalled m_tready holds it while
// the next request is already taken, and the sequencer waits to deliver.
// Reset: region 65536, head 0, tail at region end, store empty, no clearing
// pass (entries are read only after being written).
// ----------------------------------------------------------------------------
`default_nettype none

module fenced_ring_allocator #(
	parameter int RECORD_DEPTH = fra_pkg::RECORD_DEPTH_DEF,
	parameter int OFFSET_BITS  = fra_pkg::OFFSET_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration write: region_size
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [31:0]                    cfg_data,
	// request channel
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// request_size[31:0], alignment[48:32], fence_value[112:49], zero pad
	input  wire logic [fra_pkg::IN_DATA_W-1:0]  s_tdata,
	// mode[1:0]
	input  wire logic [1:0]                     s_tuser,
	// result channel
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// grant_offset[31:0], tail_position[63:32], released_count[70:64], pad
	output logic      [fra_pkg::OUT_DATA_W-1:0] m_tdata,
	// status[1:0]
	output logic      [1:0]                     m_tuser
);

	localparam int DEPTH = RECORD_DEPTH;
	localparam int OB    = OFFSET_BITS;
	localparam int IW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int AW    = (OB + 2 > 64) ? OB + 2 : 64;
	localparam logic [AW-1:0] OFF_MAX = {{(AW-OB){1'b0}}, {OB{1'b1}}};

	// sequencer states
	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_AL_ALIGN  = 4'd1;
	localparam logic [3:0] ST_AL_END    = 4'd2;
	localparam logic [3:0] ST_AL_HT     = 4'd3;
	localparam logic [3:0] ST_AL_ET     = 4'd4;
	localparam logic [3:0] ST_AL_ER     = 4'd5;
	localparam logic [3:0] ST_AL_ST     = 4'd6;
	localparam logic [3:0] ST_TAG       = 4'd7;
	localparam logic [3:0] ST_RC_CHECK  = 4'd8;
	localparam logic [3:0] ST_RC_FENCE  = 4'd9;
	localparam logic [3:0] ST_RC_END    = 4'd10;
	localparam logic [3:0] ST_RC_WCMP   = 4'd11;
	localparam logic [3:0] ST_RC_WSUB   = 4'd12;
	localparam logic [3:0] ST_DONE      = 4'd13;

	function automatic logic [IW-1:0] bump(input logic [IW-1:0] i);
		return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [OB-1:0] sat_region(input logic [31:0] v);
		logic [AW-1:0] ve;
		ve = AW'(v);
		return (ve > OFF_MAX) ? OFF_MAX[OB-1:0] : ve[OB-1:0];
	endfunction

	logic [3:0]    state_q;
	logic [OB-1:0] region_q, head_q, tail_q;
	logic [IW-1:0] oldest_q, first_q, next_q, tag_idx_q;
	logic [CW-1:0] count_q, untag_q, tag_left_q;
	logic [31:0]   size_q;
	logic [16:0]   amask_q;
	logic [63:0]   fence_q;
	logic [AW-1:0] aligned_q, end_q;
	logic [1:0]    status_q;
	logic [31:0]   grant_q;
	logic [6:0]    released_q;

	logic          out_valid_q;
	logic [1:0]    out_status_q;
	logic [31:0]   out_grant_q, out_tail_q;
	logic [6:0]    out_released_q;

	logic [AW-1:0] alu_a, alu_b, alu_sum;
	logic          alu_sub, alu_carry;

	fra_pkg::fra_store_ctl_t store_ctl;
	logic [IW-1:0] wr_addr;
	logic [OB-1:0] wr_offset, rd_offset;
	logic [63:0]   wr_fence, rd_fence;
	logic [31:0]   rd_size;

	logic          accept, grant_fire, no_room, rc_apply, rc_stop, load_out;
	logic [AW-1:0] grant_start, new_head, rc_end;
	logic [16:0]   in_align;

	assign cfg_ready = (state_q == ST_IDLE);
	assign s_tready  = (state_q == ST_IDLE) && !cfg_valid;
	assign accept    = s_tvalid && s_tready;
	assign in_align  = s_tdata[48:32];

	// shared unit operand selection
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q) inside
			ST_AL_ALIGN: begin
				alu_a = AW'(head_q);
				alu_b = AW'(amask_q);
			end
			ST_AL_END: begin
				alu_a = aligned_q;
				alu_b = AW'(size_q);
			end
			ST_AL_HT: begin
				alu_a   = AW'(head_q);
				alu_b   = AW'(tail_q);
				alu_sub = 1'b1;
			end
			ST_AL_ET: begin
				alu_a   = end_q;
				alu_b   = AW'(tail_q);
				alu_sub = 1'b1;
			end
			ST_AL_ER: begin
				alu_a   = AW'(region_q);
				alu_b   = end_q;
				alu_sub = 1'b1;
			end
			ST_AL_ST: begin
				alu_a   = AW'(size_q);
				alu_b   = AW'(tail_q);
				alu_sub = 1'b1;
			end
			ST_RC_FENCE: begin
				alu_a   = AW'(fence_q);
				alu_b   = AW'(rd_fence);
				alu_sub = 1'b1;
			end
			ST_RC_END: begin
				alu_a = AW'(rd_offset);
				alu_b = AW'(rd_size);
			end
			ST_RC_WCMP, ST_RC_WSUB: begin
				alu_a   = end_q;
				alu_b   = AW'(region_q);
				alu_sub = 1'b1;
			end
			default: begin
				alu_a   = '0;
				alu_b   = '0;
				alu_sub = 1'b0;
			end
		endcase
	end

	fra_alu #(.W(AW)) u_alu (
		.a     (alu_a),
		.b     (alu_b),
		.sub   (alu_sub),
		.sum   (alu_sum),
		.carry (alu_carry)
	);

	// allocate decisions from the compare steps
	assign grant_fire = ((state_q == ST_AL_ET) && !alu_carry)
	                 || ((state_q == ST_AL_ER) && alu_carry)
	                 || ((state_q == ST_AL_ST) && !alu_carry);
	assign no_room    = ((state_q == ST_AL_ET) || (state_q == ST_AL_ST)) && alu_carry;
	assign grant_start = (state_q == ST_AL_ST) ? '0 : aligned_q;
	assign new_head    = (state_q == ST_AL_ST) ? AW'(size_q) : end_q;

	// reclaim decisions
	assign rc_stop  = (rd_fence == '0) || !alu_carry;
	assign rc_apply = ((state_q == ST_RC_WCMP) && !alu_carry) || (state_q == ST_RC_WSUB);
	assign rc_end   = (state_q == ST_RC_WSUB) ? alu_sum : end_q;

	// record store requests
	always_comb begin
		store_ctl.alloc_we = grant_fire;
		store_ctl.fence_we = (state_q == ST_TAG);
		store_ctl.rd_en    = (state_q == ST_RC_CHECK) && (count_q > untag_q);
	end
	assign wr_addr   = (state_q == ST_TAG) ? tag_idx_q : next_q;
	assign wr_offset = grant_start[OB-1:0];
	assign wr_fence  = (state_q == ST_TAG) ? fence_q : '0;

	fra_store #(.DEPTH(DEPTH), .OB(OB), .IW(IW)) u_store (
		.clk       (clk),
		.ctl       (store_ctl),
		.wr_addr   (wr_addr),
		.wr_offset (wr_offset),
		.wr_size   (size_q),
		.wr_fence  (wr_fence),
		.rd_addr   (oldest_q),
		.rd_offset (rd_offset),
		.rd_size   (rd_size),
		.rd_fence  (rd_fence)
	);

	assign load_out = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	// sequencer and allocator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			region_q <= sat_region(fra_pkg::REGION_RESET);
			tail_q   <= sat_region(fra_pkg::REGION_RESET);
			head_q   <= '0;
			oldest_q <= '0;
			first_q  <= '0;
			next_q   <= '0;
			count_q  <= '0;
			untag_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			// restart the ring on a new region size
			state_q  <= ST_IDLE;
			region_q <= sat_region(cfg_data);
			tail_q   <= sat_region(cfg_data);
			head_q   <= '0;
			oldest_q <= '0;
			first_q  <= '0;
			next_q   <= '0;
			count_q  <= '0;
			untag_q  <= '0;
		end else begin
			unique case (state_q) inside
				ST_IDLE: begin
					if (accept) begin
						size_q     <= s_tdata[31:0];
						amask_q    <= (in_align == '0) ? '0 : in_align - 1'b1;
						fence_q    <= s_tdata[112:49];
						status_q   <= fra_pkg::STATUS_OK;
						grant_q    <= '0;
						released_q <= '0;
						tag_idx_q  <= first_q;
						tag_left_q <= untag_q;
						unique case (s_tuser)
							fra_pkg::MODE_ALLOC: begin
								if (count_q == CW'(DEPTH)) begin
									status_q <= fra_pkg::STATUS_FULL;
									state_q  <= ST_DONE;
								end else begin
									state_q <= ST_AL_ALIGN;
								end
							end
							fra_pkg::MODE_TAG: begin
								state_q <= (untag_q == '0) ? ST_DONE : ST_TAG;
							end
							fra_pkg::MODE_RECLAIM: begin
								state_q <= ST_RC_CHECK;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_AL_ALIGN: begin
					aligned_q <= alu_sum & ~AW'(amask_q);
					state_q   <= ST_AL_END;
				end
				ST_AL_END: begin
					end_q   <= alu_sum;
					state_q <= ST_AL_HT;
				end
				ST_AL_HT: begin
					state_q <= alu_carry ? ST_AL_ER : ST_AL_ET;
				end
				ST_AL_ET, ST_AL_ER, ST_AL_ST: begin
					if (grant_fire) begin
						head_q  <= new_head[OB-1:0];
						grant_q <= grant_start[31:0];
						next_q  <= bump(next_q);
						count_q <= count_q + 1'b1;
						untag_q <= untag_q + 1'b1;
						state_q <= ST_DONE;
					end else if (no_room) begin
						status_q <= fra_pkg::STATUS_NOROOM;
						state_q  <= ST_DONE;
					end else begin
						state_q <= ST_AL_ST;
					end
				end
				ST_TAG: begin
					// stamp one pending record per cycle
					tag_idx_q  <= bump(tag_idx_q);
					tag_left_q <= tag_left_q - 1'b1;
					if (tag_left_q == CW'(1)) begin
						first_q <= next_q;
						untag_q <= '0;
						state_q <= ST_DONE;
					end
				end
				ST_RC_CHECK: begin
					state_q <= (count_q > untag_q) ? ST_RC_FENCE : ST_DONE;
				end
				ST_RC_FENCE: begin
					state_q <= rc_stop ? ST_DONE : ST_RC_END;
				end
				ST_RC_END: begin
					end_q   <= alu_sum;
					state_q <= ST_RC_WCMP;
				end
				ST_RC_WCMP, ST_RC_WSUB: begin
					if (rc_apply) begin
						// retire the oldest record and move the tail to its end
						tail_q     <= (rc_end == '0) ? region_q : rc_end[OB-1:0];
						oldest_q   <= bump(oldest_q);
						count_q    <= count_q - 1'b1;
						released_q <= released_q + 1'b1;
						state_q    <= ST_RC_CHECK;
					end else begin
						state_q <= ST_RC_WSUB;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register: hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q   <= status_q;
			out_grant_q    <= grant_q;
			out_tail_q     <= 32'(tail_q);
			out_released_q <= released_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {1'b0, out_released_q, out_tail_q, out_grant_q};

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("record count exceeds store depth");

	a_untag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		untag_q <= count_q)
		else $error("more untagged records than records held");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !cfg_valid) |=> !s_tready)
		else $error("request accepted while the sequencer was busy");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !$past(m_tvalid)) |-> ($past(state_q) == ST_DONE))
		else $error("result appeared without a finished request");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the fenced ring allocator
// Streams allocate, tag and reclaim requests across several region sizes and
// handshake profiles, predicts every result in step with the accepted
// requests and compares each returned result field by field, in order.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int DEPTH       = fra_pkg::RECORD_DEPTH_DEF;
	localparam int STALL_LIMIT = 5000;

	localparam logic [1:0]  MODE_UNUSED = 2'd3;
	localparam logic [63:0] FENCE_ALL   = '1;

	typedef struct {
		logic [1:0]  mode;
		logic [31:0] req_len;
		logic [16:0] align;
		logic [63:0] fence;
		bit          hold;   // wait until nothing is outstanding before sending
	} ring_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] grant;
		logic [31:0] tail;
		logic [6:0]  freed;
	} ring_res_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [31:0]                    cfg_data  = '0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [fra_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
	logic [1:0]                     s_tuser   = fra_pkg::MODE_ALLOC;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [fra_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [1:0]                     m_tuser;

	// request queue, request being presented and results still due
	ring_req_t request_q [$];
	ring_req_t cur_req;
	ring_res_t due_results [$];

	int          sent_cnt = 0;
	int          seen_cnt = 0;
	int          queued = 0;
	int          fail_count = 0;
	int          quiet_cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int          grant_cnt = 0;
	int          noroom_cnt = 0;
	int          full_cnt = 0;
	int          retired_cnt = 0;
	logic [63:0] fence_now;

	// ring model state
	logic [31:0] ring_size, head_pos, tail_pos;
	logic [31:0] rec_base [DEPTH];
	logic [31:0] rec_len [DEPTH];
	logic [63:0] rec_fence [DEPTH];
	int unsigned front_idx, untag_idx, free_idx, held_cnt, untag_cnt;

	fenced_ring_allocator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// empty the ring and restart head and tail for a region size
	function automatic void restart_ring(input logic [31:0] region);
		ring_size = region;
		head_pos  = '0;
		tail_pos  = region;
		front_idx = 0;
		untag_idx = 0;
		free_idx  = 0;
		held_cnt  = 0;
		untag_cnt = 0;
	endfunction

	// advance the ring by one request and return the result it should give
	function automatic ring_res_t apply_request(input ring_req_t r);
		ring_res_t   res;
		logic [63:0] a, aligned, start, fin;
		bit          ok;
		int unsigned i;
		res = '0;
		res.status = fra_pkg::STATUS_OK;
		case (r.mode)
			fra_pkg::MODE_ALLOC: begin
				if (held_cnt >= DEPTH) begin
					res.status = fra_pkg::STATUS_FULL;
					full_cnt++;
				end else begin
					a = (r.align == '0) ? 64'd1 : 64'(r.align);
					aligned = (64'(head_pos) + a - 64'd1) & ~(a - 64'd1);
					ok = 1'b1;
					start = '0;
					fin = 64'(r.req_len);
					if (head_pos < tail_pos) begin
						ok = (aligned + r.req_len) < tail_pos;
						start = aligned;
						fin = aligned + r.req_len;
					end else if (aligned + r.req_len <= ring_size) begin
						start = aligned;
						fin = aligned + r.req_len;
					end else begin
						// wrap to offset zero, room only below the tail
						ok = r.req_len < tail_pos;
					end
					if (!ok) begin
						res.status = fra_pkg::STATUS_NOROOM;
						noroom_cnt++;
					end else begin
						head_pos = fin[31:0];
						res.grant = start[31:0];
						rec_base[free_idx] = start[31:0];
						rec_len[free_idx] = r.req_len;
						rec_fence[free_idx] = '0;
						free_idx = (free_idx + 1) % DEPTH;
						held_cnt++;
						untag_cnt++;
						grant_cnt++;
					end
				end
			end
			fra_pkg::MODE_TAG: begin
				i = untag_idx;
				repeat (untag_cnt) begin
					rec_fence[i] = r.fence;
					i = (i + 1) % DEPTH;
				end
				untag_idx = free_idx;
				untag_cnt = 0;
			end
			fra_pkg::MODE_RECLAIM: begin
				// retire tagged records in order while their fence has completed
				while (held_cnt > untag_cnt && rec_fence[front_idx] != '0
						&& rec_fence[front_idx] <= r.fence) begin
					fin = 64'(rec_base[front_idx]) + 64'(rec_len[front_idx]);
					if (fin >= 64'(ring_size))
						fin = fin - 64'(ring_size);
					tail_pos = (fin == '0) ? ring_size : fin[31:0];
					front_idx = (front_idx + 1) % DEPTH;
					held_cnt--;
					res.freed = res.freed + 7'd1;
					retired_cnt++;
				end
			end
			default: ;
		endcase
		res.tail = tail_pos;
		return res;
	endfunction

	task automatic queue_req(input logic [1:0] mode, input logic [31:0] req_len,
			input logic [16:0] align, input logic [63:0] fence, input bit hold = 1'b0);
		ring_req_t r;
		r.mode    = mode;
		r.req_len = req_len;
		r.align   = align;
		r.fence   = fence;
		r.hold    = hold;
		request_q.insert(request_q.size(), r);
		if (mode != MODE_UNUSED)
			queued++;
	endtask

	task automatic flag_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// wait until every request is sent and answered, then let the block settle
	task automatic wait_drained(input int extra);
		do @(negedge clk);
		while (request_q.size() != 0 || s_tvalid || sent_cnt != seen_cnt);
		repeat (extra) @(posedge clk);
	endtask

	// present requests from the queue; hold each until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			sent_cnt <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				due_results.insert(due_results.size(), apply_request(cur_req));
				sent_cnt <= sent_cnt + 1;
			end
			if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct
					&& !(request_q[0].hold && (s_tvalid || sent_cnt != seen_cnt))) begin
				cur_req = request_q[0];
				request_q.delete(0);
				s_tvalid <= 1'b1;
				s_tdata <= fra_pkg::IN_DATA_W'({cur_req.fence, cur_req.align,
					cur_req.req_len});
				s_tuser <= cur_req.mode;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// take results, compare against the oldest one due
	always @(posedge clk or negedge arst_n) begin : result_check
		ring_res_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			seen_cnt <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.status = m_tuser;
				got.grant  = m_tdata[31:0];
				got.tail   = m_tdata[63:32];
				got.freed  = m_tdata[70:64];
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result, status %0d grant 0x%0h tail 0x%0h",
						$time, got.status, got.grant, got.tail);
					fail_count++;
				end else begin
					want = due_results[0];
					due_results.delete(0);
					flag_field("status", 32'(want.status), 32'(got.status));
					flag_field("grant_offset", want.grant, got.grant);
					flag_field("tail_position", want.tail, got.tail);
					flag_field("released_count", 32'(want.freed), 32'(got.freed));
				end
				seen_cnt <= seen_cnt + 1;
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// end the run if nothing moves on any channel for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [31:0] regions [5];
		logic [31:0] req_len;
		logic [63:0] done;
		int          ph, k, target;
		int unsigned roll;
		regions[0] = fra_pkg::REGION_RESET;
		regions[1] = 32'hFFFF_FFFF;
		regions[2] = 32'd1;
		regions[3] = $urandom_range(256, 4096);
		regions[4] = $urandom_range(32'h0010_0000, 32'h7FFF_FFFF);
		restart_ring(fra_pkg::REGION_RESET);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (ph = 0; ph < 5; ph++) begin
			// change region size only while the block is idle
			if (ph != 0) begin
				wait_drained(20);
				@(posedge clk);
				cfg_valid <= 1'b1;
				cfg_data <= regions[ph];
				do @(posedge clk);
				while (cfg_ready !== 1'b1);
				cfg_valid <= 1'b0;
				restart_ring(regions[ph]);
			end
			case (ph % 4)
				0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
				1: begin send_idle_pct <= 73; recv_stall_pct <= 0;  end
				2: begin send_idle_pct <= 0;  recv_stall_pct <= 73; end
				default: begin send_idle_pct <= 10; recv_stall_pct <= 10; end
			endcase
			@(negedge clk);
			fence_now = {$urandom, $urandom};
			if (fence_now > 64'hFFFF_FFFF_FFFF_0000)
				fence_now = fence_now - 64'h1_0000;

			// directed requests on the reset region
			if (ph == 0) begin
				// zero alignment counts as one
				queue_req(fra_pkg::MODE_ALLOC, 32'd0, 17'd0, '0);
				queue_req(fra_pkg::MODE_ALLOC, 32'd100, 17'd1, '0);
				// alignment not a power of two
				queue_req(fra_pkg::MODE_ALLOC, 32'd10, 17'd48, '0);
				// largest alignment, no room
				queue_req(fra_pkg::MODE_ALLOC, 32'd1000, 17'h10000, '0);
				// largest size
				queue_req(fra_pkg::MODE_ALLOC, 32'hFFFF_FFFF, 17'd1, '0);
				queue_req(MODE_UNUSED, '1, '1, FENCE_ALL);
				queue_req(fra_pkg::MODE_TAG, '0, 17'd1, 64'd5);
				// nothing pending
				queue_req(fra_pkg::MODE_TAG, '0, 17'd1, 64'd7);
				// fence not yet complete
				queue_req(fra_pkg::MODE_RECLAIM, '0, 17'd1, 64'd4);
				queue_req(fra_pkg::MODE_RECLAIM, '0, 17'd1, 64'd5);
				queue_req(fra_pkg::MODE_ALLOC, 32'd60000, 17'd4096, '0);
				// too big to wrap
				queue_req(fra_pkg::MODE_ALLOC, 32'd2000, 17'd1, '0);
				// still fits below the region end, no wrap
				queue_req(fra_pkg::MODE_ALLOC, 32'd100, 17'd1, '0);
				queue_req(fra_pkg::MODE_TAG, '0, 17'd1, 64'd9);
				queue_req(fra_pkg::MODE_RECLAIM, '0, 17'd1, FENCE_ALL);
				// no room, neither before the region end nor below the tail
				queue_req(fra_pkg::MODE_ALLOC, 32'd65436, 17'd1, '0);
				queue_req(fra_pkg::MODE_TAG, '0, 17'd1, 64'd10);
				// nothing tagged to retire, tail stays put
				queue_req(fra_pkg::MODE_RECLAIM, '0, 17'd1, 64'd10, 1'b1);
				queue_req(fra_pkg::MODE_ALLOC, 32'd5, 17'd1, '0);
				// only untagged records
				queue_req(fra_pkg::MODE_RECLAIM, '0, 17'd1, FENCE_ALL);
				queue_req(fra_pkg::MODE_TAG, '0, 17'd1, FENCE_ALL);
				queue_req(fra_pkg::MODE_RECLAIM, '0, 17'd1, FENCE_ALL);
			end

			target = queued + ((ph == 2) ? 40 : 210);

			// flush, then overfill the record store
			fence_now = fence_now + 64'd1;
			queue_req(fra_pkg::MODE_TAG, $urandom, 17'd1, fence_now);
			queue_req(fra_pkg::MODE_RECLAIM, $urandom, 17'd1, FENCE_ALL);
			repeat (DEPTH + 2)
				queue_req(fra_pkg::MODE_ALLOC,
					$urandom_range(0, (regions[ph] >= 1024) ? 3 : 0),
					17'd1, {$urandom, $urandom});
			fence_now = fence_now + 64'd1;
			queue_req(fra_pkg::MODE_TAG, $urandom, 17'd1, fence_now);
			queue_req(fra_pkg::MODE_RECLAIM, $urandom, 17'd1, fence_now, 1'b1);

			while (queued < target) begin
				roll = $urandom_range(99);
				if (roll < 82) begin
					// frame: a few allocates, usually one tag, usually a reclaim
					k = $urandom_range(1, 6);
					repeat (k) begin
						roll = $urandom_range(99);
						if (roll < 60)
							req_len = $urandom_range(0, regions[ph] >> 3);
						else if (roll < 85)
							req_len = $urandom_range(0, regions[ph] >> 1);
						else if (roll < 97)
							req_len = $urandom_range(0, regions[ph]);
						else
							req_len = $urandom;
						queue_req(fra_pkg::MODE_ALLOC, req_len,
							($urandom_range(9) != 0) ? 17'd1 << $urandom_range(0, 16)
								: 17'($urandom),
							{$urandom, $urandom});
					end
					if ($urandom_range(9) != 0) begin
						fence_now = fence_now + 64'($urandom_range(1, 3));
						queue_req(fra_pkg::MODE_TAG, $urandom, 17'($urandom), fence_now);
					end
					roll = $urandom_range(99);
					if (roll < 70) begin
						if (roll < 10)
							done = FENCE_ALL;
						else if (roll < 45)
							done = fence_now;
						else
							done = fence_now - 64'($urandom_range(0, 6));
						queue_req(fra_pkg::MODE_RECLAIM, $urandom, 17'($urandom), done,
							roll < 4);
					end
				end else begin
					// noise: any mode, any field values
					queue_req(2'($urandom_range(0, 3)), $urandom, 17'($urandom),
						{$urandom, $urandom});
				end
			end

			// zero fence blocks reclaim until the next region write
			if (ph == 0) begin
				queue_req(fra_pkg::MODE_ALLOC, 32'd16, 17'd1, '0);
				queue_req(fra_pkg::MODE_TAG, '0, 17'd1, '0);
				queue_req(fra_pkg::MODE_RECLAIM, '0, 17'd1, FENCE_ALL);
				queue_req(fra_pkg::MODE_ALLOC, 32'd16, 17'd1, '0);
			end
		end

		wait_drained(400);
		$display("Checked %0d results over five region sizes from 1 to 2^32-1",
			seen_cnt);
		$display("and four handshake profiles: %0d grants, %0d no-room, %0d store-full, %0d retired",
			grant_cnt, noroom_cnt, full_cnt, retired_cnt);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/fra_pkg.sv
hdl/fra_alu.sv
hdl/fra_store.sv
hdl/fenced_ring_allocator.sv
verif/tb_top.sv
